@@ rtl/core/text_console_cursor_scroll_macros.svh @@
// Assertion macros shared by the console cursor and scroll RTL.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tccs_pkg.sv @@
// Shared types and constants of the text console cursor and scroll block.
// No dependencies; tccs_datapath, tccs_ctrl and the top level import this package.
package tccs_pkg;

  // Geometry and register defaults.
  localparam int unsigned TCCS_ROWS    = 25;
  localparam logic [7:0]  COLS_RESET   = 8'd80;
  localparam logic [7:0]  COLS_MAX     = 8'd132;
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned DIV_W        = 12;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_COLUMNS = 1'b0;

  // Character codes with special meaning.
  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // Blank cell: attribute 0x07, character 0.
  localparam logic [10:0] CELL_BLANK = 11'h700;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_char;
    logic div_start;
    logic take_col;
    logic take_row;
    logic update;
    logic load_out;
  } tccs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } tccs_stat_t;

endpackage

@@ rtl/core/tccs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the console datapath.
// Depends on the assertion macro header.
`include "text_console_cursor_scroll_macros.svh"

module tccs_div #(
  parameter int unsigned W = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W:0]       shifted;
  logic             fits;

  // Trial subtraction of one step.
  assign shifted = {rem, quo[W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  // Iteration registers and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? W'(shifted - {1'b0, divisor}) : shifted[W-1:0];
        quo <= {quo[W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  `TCCS_ASSERT_NOW(a_rem_below_divisor, done, rem < divisor, "remainder not below divisor")

endmodule

@@ rtl/core/tccs_datapath.sv @@
// Datapath of the console block: configuration, cursor and top row state,
// divider, cursor update and the result register. Uses tccs_pkg and tccs_div.
`include "text_console_cursor_scroll_macros.svh"

module tccs_datapath #(
  parameter int unsigned ROWS = tccs_pkg::TCCS_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  tccs_pkg::tccs_cmd_t  cmd,
  output tccs_pkg::tccs_stat_t stat,
  input  logic               col_wr,
  input  logic [7:0]         col_wdata,
  output logic [7:0]         columns,
  input  logic [7:0]         char_code,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               cell_write,
  output logic [11:0]        cell_index,
  output logic [10:0]        cell_value,
  output logic               clear_row,
  output logic [4:0]         clear_row_index,
  output logic [4:0]         top_row,
  output logic [4:0]         cursor_row,
  output logic [7:0]         cursor_col
);
  import tccs_pkg::*;

  localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);
  localparam logic [4:0] ROW_NUM  = 5'(ROWS);

  // Reciprocal of ROWS, exact for every 12-bit quotient while ROWS is below 32.
  localparam int unsigned REC_SHIFT = DIV_W + 5;
  localparam logic [REC_SHIFT-1:0] ROW_RECIP = REC_SHIFT'((2 ** REC_SHIFT + ROWS - 1) / ROWS);

  logic [11:0] cursor_index;
  logic [4:0]  start_row;
  logic [7:0]  char_q;
  logic [7:0]  col_q;
  logic [4:0]  row_q;
  logic [7:0]  eff_cols;

  logic [DIV_W-1:0] div_dividend, div_divisor, div_quo, div_rem;
  logic             div_done;

  // Row reduction modulo ROWS.
  logic [DIV_W+REC_SHIFT-1:0] recip_prod;
  logic [DIV_W-1:0]           row_quo, row_mod;

  // Update stage registers.
  logic [4:0]  nrow, wrow, ntop, cidx;
  logic [7:0]  ncol, wcol;
  logic        wr, clr;
  logic [10:0] wval;

  // Next values of the update stage.
  logic [4:0]  nrow_next, wrow_next, ntop_next, cidx_next;
  logic [7:0]  ncol_next, wcol_next;
  logic        wr_next, clr_next, check;
  logic [10:0] wval_next;

  logic [12:0] widx_full, cur_full;
  logic [4:0]  srow;
  logic [4:0]  scroll_top;

  // Columns clamped to the legal range.
  always_comb begin
    if (columns == 8'd0) begin
      eff_cols = 8'd1;
    end else if (columns > COLS_MAX) begin
      eff_cols = COLS_MAX;
    end else begin
      eff_cols = columns;
    end
  end

  // The divider splits the cursor into a row quotient and a column.
  assign div_dividend = cursor_index;
  assign div_divisor  = {4'd0, eff_cols};

  tccs_div #(.W(DIV_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // The row quotient is reduced modulo ROWS: estimate, then subtract.
  assign recip_prod = {{REC_SHIFT{1'b0}}, div_quo} * {{DIV_W{1'b0}}, ROW_RECIP};
  assign row_mod    = div_quo - row_quo * DIV_W'(ROWS);

  // Cursor movement on the store row and column.
  always_comb begin
    nrow_next = row_q;
    ncol_next = col_q;
    wrow_next = row_q;
    wcol_next = col_q;
    wr_next   = 1'b0;
    wval_next = '0;
    check     = 1'b0;
    case (char_q)
      CH_NUL: begin
      end
      CH_NL: begin
        ncol_next = '0;
        nrow_next = (row_q == ROW_LAST) ? 5'd0 : row_q + 5'd1;
        check     = 1'b1;
      end
      CH_CR: begin
        ncol_next = '0;
      end
      CH_BS: begin
        if (!(row_q == start_row && col_q == 8'd0)) begin
          if (col_q == 8'd0) begin
            ncol_next = eff_cols - 8'd1;
            nrow_next = (row_q == 5'd0) ? ROW_LAST : row_q - 5'd1;
          end else begin
            ncol_next = col_q - 8'd1;
          end
        end
        wr_next   = 1'b1;
        wrow_next = nrow_next;
        wcol_next = ncol_next;
        wval_next = CELL_BLANK;
      end
      default: begin
        wr_next   = 1'b1;
        wval_next = CELL_BLANK | {3'd0, char_q};
        if (col_q == eff_cols - 8'd1) begin
          ncol_next = '0;
          nrow_next = (row_q == ROW_LAST) ? 5'd0 : row_q + 5'd1;
        end else begin
          ncol_next = col_q + 8'd1;
        end
        check = 1'b1;
      end
    endcase
    // Reaching the first cell of the top row scrolls the screen.
    clr_next  = check && nrow_next == start_row && ncol_next == 8'd0;
    cidx_next = clr_next ? start_row : 5'd0;
    if (clr_next) begin
      ntop_next = (start_row == ROW_LAST) ? 5'd0 : start_row + 5'd1;
    end else begin
      ntop_next = start_row;
    end
  end

  // Store indexes and the screen-relative row of the result.
  assign widx_full = {8'd0, wrow} * {5'd0, eff_cols} + {5'd0, wcol};
  assign cur_full  = {8'd0, nrow} * {5'd0, eff_cols} + {5'd0, ncol};
  assign srow      = (nrow >= ntop) ? nrow - ntop : nrow + ROW_NUM - ntop;

  // Top row expected after a scroll of the reported row.
  assign scroll_top = (clear_row_index == ROW_LAST) ? 5'd0 : clear_row_index + 5'd1;

  assign stat.div_done = div_done;
  assign stat.out_free = !res_valid || !res_stall;

  // State, stage and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      columns      <= COLS_RESET;
      cursor_index <= '0;
      start_row    <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (col_wr) begin
        columns <= col_wdata;
      end
      if (cmd.load_char) begin
        char_q <= char_code;
      end
      if (cmd.take_col) begin
        col_q   <= div_rem[7:0];
        row_quo <= recip_prod[DIV_W+REC_SHIFT-1:REC_SHIFT];
      end
      if (cmd.take_row) begin
        row_q <= row_mod[4:0];
      end
      if (cmd.update) begin
        nrow <= nrow_next;
        ncol <= ncol_next;
        wrow <= wrow_next;
        wcol <= wcol_next;
        wr   <= wr_next;
        wval <= wval_next;
        clr  <= clr_next;
        cidx <= cidx_next;
        ntop <= ntop_next;
      end
      if (cmd.load_out) begin
        res_valid       <= 1'b1;
        cursor_index    <= cur_full[11:0];
        start_row       <= ntop;
        cell_write      <= wr;
        cell_index      <= wr ? widx_full[11:0] : 12'd0;
        cell_value      <= wr ? wval : 11'd0;
        clear_row       <= clr;
        clear_row_index <= cidx;
        top_row         <= ntop;
        cursor_row      <= srow;
        cursor_col      <= ncol;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  `TCCS_ASSERT_NOW(a_top_in_range, 1'b1, start_row <= ROW_LAST, "top row out of range")
  `TCCS_ASSERT_NOW(a_col_in_range, res_valid, cursor_col < eff_cols, "cursor column past row")
  `TCCS_ASSERT_NOW(a_scroll_advances, res_valid && clear_row, top_row == scroll_top, "top row kept")

endmodule

@@ rtl/core/tccs_ctrl.sv @@
// Controller of the console block: sequences the division, the row reduction,
// the update and the result load. Uses tccs_pkg for the command and status structs.
module tccs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  output tccs_pkg::tccs_cmd_t  cmd,
  input  tccs_pkg::tccs_stat_t stat
);
  import tccs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_UPDATE,
    ST_DELIVER
  } state_t;

  state_t state;

  // State and the input stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_stall <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (char_valid) begin
            state      <= ST_DIV_COL;
            char_stall <= 1'b1;
          end
        end
        ST_DIV_COL: begin
          if (stat.div_done) begin
            state <= ST_DIV_ROW;
          end
        end
        ST_DIV_ROW: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state <= ST_DELIVER;
        end
        ST_DELIVER: begin
          if (stat.out_free) begin
            state      <= ST_IDLE;
            char_stall <= 1'b0;
          end
        end
        default: begin
          state      <= ST_IDLE;
          char_stall <= 1'b0;
        end
      endcase
    end
  end

  // Commands decoded from state and status.
  always_comb begin
    cmd.load_char = (state == ST_IDLE) && char_valid;
    cmd.div_start = cmd.load_char;
    cmd.take_col  = (state == ST_DIV_COL) && stat.div_done;
    cmd.take_row  = (state == ST_DIV_ROW);
    cmd.update    = (state == ST_UPDATE);
    cmd.load_out  = (state == ST_DELIVER) && stat.out_free;
  end

endmodule

@@ rtl/core/text_console_cursor_scroll.sv @@
// Text console cursor and scroll control: top level with the APB-style port.
// Uses tccs_pkg, tccs_ctrl and tccs_datapath (which holds tccs_div).
//
// Usage: one character code per transaction on char_code (char_valid and
// char_stall). Each accepted code yields exactly one result transaction on
// res_valid and res_stall: the cell write, the row clear, the top row and the
// cursor position on screen. Codes 10, 13 and 8 are newline, return and
// backspace, 0 changes nothing, all others are written with attribute 0x07.
// Steps: the bit-serial divider splits the cursor by columns, the row is then
// reduced modulo ROWS by a reciprocal multiplication, the update stage runs
// and the result register is loaded. char_stall stays high from acceptance
// until that load, so a new code waits until the last one is through.
// The next code is accepted while an earlier result still waits in the
// output register; a stalled receiver holds the result and, once a second
// result is ready, holds char_stall high as well.
// Reset (rst, synchronous) sets columns to 80, cursor and top row to zero.
// The columns register is at byte address 0; write it only while idle.
module text_console_cursor_scroll #(
  parameter int unsigned ROWS = tccs_pkg::TCCS_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tccs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        char_valid,
  output logic                        char_stall,
  input  logic [7:0]                  char_code,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        cell_write,
  output logic [11:0]                 cell_index,
  output logic [10:0]                 cell_value,
  output logic                        clear_row,
  output logic [4:0]                  clear_row_index,
  output logic [4:0]                  top_row,
  output logic [4:0]                  cursor_row,
  output logic [7:0]                  cursor_col
);
  import tccs_pkg::*;

  tccs_cmd_t  cmd;
  tccs_stat_t stat;
  logic       col_wr;
  logic [7:0] columns;
  logic       reg_sel;

  // Register decode: the upper address bit selects the register.
  assign reg_sel = paddr[ADDR_W-1];
  assign pready  = 1'b1;
  assign col_wr  = psel && penable && pwrite && pready && (reg_sel == REG_COLUMNS);
  assign prdata  = (reg_sel == REG_COLUMNS) ? {24'd0, columns} : 32'd0;

  tccs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  tccs_datapath #(.ROWS(ROWS)) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .col_wr          (col_wr),
    .col_wdata       (pwdata[7:0]),
    .columns         (columns),
    .char_code       (char_code),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .cell_write      (cell_write),
    .cell_index      (cell_index),
    .cell_value      (cell_value),
    .clear_row       (clear_row),
    .clear_row_index (clear_row_index),
    .top_row         (top_row),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col)
  );

endmodule
